// File: src/mean_and_std_deviation_defines.svh
// ----------------------------------------------------------------------------
// Mean and standard deviation: assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MEAN_AND_STD_DEVIATION_DEFINES_SVH
`define MEAN_AND_STD_DEVIATION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/msd_pkg.sv
// ----------------------------------------------------------------------------
// Mean and standard deviation package
// Widths, payload types, datapath opcodes and controller states.
// ----------------------------------------------------------------------------
package msd_pkg;

   localparam int MAX_COUNT   = 1024;
   localparam int CNT_W       = $clog2(MAX_COUNT + 1);
   localparam int SAMPLE_W    = 16;
   localparam int SQR_W       = 2 * SAMPLE_W;
   localparam int SUM_W       = 27;
   localparam int SQ_W        = 42;
   localparam int ABS_W       = SUM_W - 1;
   localparam int VAR_W       = 2 * ABS_W;
   localparam int PROD_W      = CNT_W + SQ_W;
   localparam int ROOT_W      = VAR_W / 2;
   localparam int REM_W       = ROOT_W + 3;
   localparam int DIV_W       = ABS_W;
   localparam int MEAN_W      = 16;
   localparam int DEV_W       = 16;
   localparam int COUNT_OUT_W = 11;
   localparam int MUL_STEPS   = CNT_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int DIV_STEPS   = DIV_W;
   localparam int STEPS_MAX   = (SQRT_STEPS > MUL_STEPS) ?
                                ((SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS) :
                                ((MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS);
   localparam int STEP_W      = $clog2(STEPS_MAX);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean_value;
      logic [DEV_W-1:0]         std_deviation;
      logic [COUNT_OUT_W-1:0]   sample_count;
      logic                     overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCUM,
      OP_SETUP,
      OP_MUL,
      OP_DIFF,
      OP_SQRT,
      OP_DLOAD_DEV,
      OP_DLOAD_MEAN,
      OP_DIV,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_SETUP,
      ST_MUL,
      ST_DIFF,
      ST_SQRT,
      ST_DLOAD_DEV,
      ST_DIV_DEV,
      ST_DLOAD_MEAN,
      ST_DIV_MEAN,
      ST_FINISH
   } state_type;

endpackage

// File: src/mean_and_std_deviation.sv
// ----------------------------------------------------------------------------
// Mean and standard deviation
// Population mean and standard deviation of a set of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage: send samples on the req_ channel (valid/ready), one beat each, and
// mark the final sample of a set with last_sample. Samples are accumulated at
// one per cycle while req_ready is high. Beyond MAX_COUNT samples, further
// samples are dropped and the overflowed flag of the set is raised.
// After the last beat, req_ready drops while the result is computed: a setup
// step, a shift-add multiply for n*Q, a subtract step, a bit-serial square
// root and two restoring divisions sharing one divider, each division after
// its own load step. The result beat appears on rsp_ after the final step;
// the iterative square root and divider take most of that computation.
// The result sits in an output register, so the next set is accepted while
// the receiver stalls; only when that next set finishes as well does the
// block hold in its final step until the earlier beat is taken.
// Reset clears the accumulators and the result valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "mean_and_std_deviation_defines.svh"

module mean_and_std_deviation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  msd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output msd_pkg::rsp_type rsp_data
);
   import msd_pkg::*;

   cmd_type    cmd;
   status_type status;

   msd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_sample),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `MSD_ASSERT_NEXT(a_last_starts_compute, req_valid && req_ready && req_data.last_sample, cmd.op == OP_SETUP && !req_ready, "last sample did not start computation")
   `MSD_ASSERT_SAME(a_accum_on_beat, cmd.op == OP_ACCUM, req_valid && req_ready, "accumulate without an input beat")
   `MSD_ASSERT_SAME(a_finish_when_free, cmd.op == OP_FINISH, !status.rsp_busy, "result overwrote a waiting beat")
   `MSD_ASSERT_SAME(a_overflow_count, rsp_valid && rsp_data.overflowed, rsp_data.sample_count == COUNT_OUT_W'(MAX_COUNT), "overflow flagged below capacity")

endmodule

// File: src/msd_datapath.sv
// ----------------------------------------------------------------------------
// Mean and standard deviation datapath
// Accumulators, serial multiplier, bit-serial square root, restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module msd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  msd_pkg::req_type    req_data,
   input  msd_pkg::cmd_type    cmd,
   output msd_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output msd_pkg::rsp_type    rsp_data
);
   import msd_pkg::*;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic                    drop_ff, drop_in;
   logic                    neg_ff, neg_in;
   logic [ABS_W-1:0]        abs_ff, abs_in;
   logic [VAR_W-1:0]        s2_ff, s2_in;
   logic [CNT_W-1:0]        nsh_ff, nsh_in;
   logic [PROD_W-1:0]       mq_ff, mq_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [VAR_W-1:0]        var_ff, var_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [DIV_W-1:0]        dq_ff, dq_in;
   logic [CNT_W-1:0]        dr_ff, dr_in;
   logic [DEV_W-1:0]        dev_ff, dev_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic signed [SQR_W-1:0] sq_full;
   logic [SQR_W-1:0]        sq_mag;
   logic signed [SUM_W-1:0] sum_neg;
   logic [PROD_W-1:0]       diff;
   logic                    diff_ok;
   logic [REM_W-1:0]        rem_sh;
   logic [REM_W-1:0]        trial;
   logic [CNT_W:0]          div_t;
   logic                    div_ge;
   logic                    round_up;
   logic [DIV_W-1:0]        mag;
   logic [DIV_W-1:0]        mean_full;

   always_comb begin
      sq_full  = req_data.sample * req_data.sample;
      sq_mag   = sq_full;
      sum_neg  = -sum_ff;
      s2_in    = abs_ff * abs_ff;
      diff     = prod_ff - PROD_W'(s2_ff);
      diff_ok  = prod_ff >= PROD_W'(s2_ff);
      rem_sh   = {rem_ff[REM_W-3:0], var_ff[VAR_W-1 -: 2]};
      trial    = REM_W'({root_ff, 2'b01});
      div_t    = {dr_ff, dq_ff[DIV_W-1]};
      div_ge   = div_t >= {1'b0, count_ff};
      round_up = neg_ff & (|dr_ff);
      mag      = dq_ff + DIV_W'(round_up);
      mean_full = neg_ff ? -mag : mag;

      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      drop_in      = drop_ff;
      neg_in       = neg_ff;
      abs_in       = abs_ff;
      nsh_in       = nsh_ff;
      mq_in        = mq_ff;
      prod_in      = prod_ff;
      var_in       = var_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      dev_in       = dev_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      case (cmd.op)
         OP_ACCUM: begin
            if (count_ff < CNT_W'(MAX_COUNT)) begin
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + SUM_W'(req_data.sample);
               sq_in    = sq_ff + SQ_W'(sq_mag);
            end else begin
               drop_in = 1'b1;
            end
         end
         OP_SETUP: begin
            neg_in  = sum_ff[SUM_W-1];
            abs_in  = ABS_W'(sum_ff[SUM_W-1] ? sum_neg : sum_ff);
            nsh_in  = count_ff;
            mq_in   = PROD_W'(sq_ff);
            prod_in = '0;
         end
         OP_MUL: begin
            if (nsh_ff[0]) begin
               prod_in = prod_ff + mq_ff;
            end
            mq_in  = mq_ff << 1;
            nsh_in = nsh_ff >> 1;
         end
         OP_DIFF: begin
            // variance times n squared; clamp at zero
            var_in  = diff_ok ? VAR_W'(diff) : '0;
            rem_in  = '0;
            root_in = '0;
         end
         OP_SQRT: begin
            var_in = var_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_DLOAD_DEV: begin
            dq_in = DIV_W'(root_ff);
            dr_in = '0;
         end
         OP_DLOAD_MEAN: begin
            dev_in = dq_ff[DEV_W-1:0];
            dq_in  = abs_ff;
            dr_in  = '0;
         end
         OP_DIV: begin
            dq_in = {dq_ff[DIV_W-2:0], div_ge};
            dr_in = div_ge ? CNT_W'(div_t - {1'b0, count_ff}) : div_t[CNT_W-1:0];
         end
         OP_FINISH: begin
            rsp_in.mean_value    = mean_full[MEAN_W-1:0];
            rsp_in.std_deviation = dev_ff;
            rsp_in.sample_count  = COUNT_OUT_W'(count_ff);
            rsp_in.overflowed    = drop_ff;
            rsp_valid_in         = 1'b1;
            // clear for the next set
            count_in = '0;
            sum_in   = '0;
            sq_in    = '0;
            drop_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      abs_ff  <= abs_in;
      s2_ff   <= s2_in;
      nsh_ff  <= nsh_in;
      mq_ff   <= mq_in;
      prod_ff <= prod_in;
      var_ff  <= var_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      dev_ff  <= dev_in;
      rsp_ff  <= rsp_in;
   end

   assign status.rsp_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

// File: src/msd_ctrl.sv
// ----------------------------------------------------------------------------
// Mean and standard deviation controller
// Sequences accumulation, then multiply, square root and the two divisions.
// ----------------------------------------------------------------------------
module msd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  msd_pkg::status_type status,
   output msd_pkg::cmd_type    cmd
);
   import msd_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;

      case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_ACCUM;
               if (req_last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.op   = OP_SETUP;
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op = OP_MUL;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DIFF;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DLOAD_DEV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DLOAD_DEV: begin
            cmd.op   = OP_DLOAD_DEV;
            state_in = ST_DIV_DEV;
         end
         ST_DIV_DEV: begin
            cmd.op = OP_DIV;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DLOAD_MEAN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DLOAD_MEAN: begin
            cmd.op   = OP_DLOAD_MEAN;
            state_in = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.op = OP_DIV;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FINISH: begin
            // hold while the previous result beat is still waiting
            if (!status.rsp_busy) begin
               cmd.op   = OP_FINISH;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule
